[design/omni_mix_pkg.sv]
// Shared types, constants and the sine table builder for the omni chassis mixer.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package omni_mix_pkg;

    typedef enum logic [1:0] {
        OP_COMMAND = 2'd0,
        OP_HEADING = 2'd1,
        OP_STOP    = 2'd2,
        OP_UPDATE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_INACTIVE = 2'd0,
        STAT_DRIVE    = 2'd1,
        STAT_NO_LIMIT = 2'd2
    } t_status;

    localparam logic [2:0] CFG_GAIN_P   = 3'd0;
    localparam logic [2:0] CFG_GAIN_D   = 3'd1;
    localparam logic [2:0] CFG_FF_PITCH = 3'd2;
    localparam logic [2:0] CFG_FF_ROLL  = 3'd3;

    localparam int DEADBAND     = 123;
    localparam int MAX_ROT      = 1434;
    localparam int HALF_TURN    = 11520;
    localparam int FULL_TURN    = 23040;
    localparam int QUARTER_TURN = 5760;
    localparam int UNIT_Q12     = 4096;
    localparam int SIN_ONE      = 16384;
    localparam int GAIN_P_MAX   = 13107;
    localparam int GAIN_D_MAX   = 3277;
    localparam int FF_LIMIT     = 8192;
    localparam int GAIN_P_RESET = 2621;
    localparam int GAIN_D_RESET = 393;
    localparam int NUM_WHEELS   = 4;
    localparam int QUOT_BITS    = 15;

    // Division by 90 through a reciprocal; the index divide by 5760 is a shift by 6 and this.
    localparam int SIX_BITS     = 6;
    localparam int DIV_NINETY   = 90;
    localparam int RECIP_SHIFT  = 26;
    localparam longint RECIP_90 = (64'd1 << RECIP_SHIFT) / DIV_NINETY;
    localparam int RECIP_BITS   = $clog2(RECIP_90 + 1);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic       take;
        logic       err_load;
        logic       sin_a;
        logic       sin_b;
        logic       ff_load;
        logic       roll_sel;
        logic       head_p;
        logic       head_d;
        logic       mix;
        logic       wheel_mul;
        logic       div_step;
        logic       div_last;
        logic [1:0] wheel;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic quick;
    } t_dp_stat;

    // Q1.14 sine of an angle given in Q2.30 radians, from a six term Taylor series.
    function automatic logic [14:0] sine_entry(input logic [63:0] x);
        logic [63:0] one;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        one = 64'd1 << 30;
        x2  = (x * x) >> 30;
        t   = one;
        for (int k = 0; k < 5; k++) begin
            unique case (k)
                0: t = one - (((x2 * t) >> 30) / 64'd110);
                1: t = one - (((x2 * t) >> 30) / 64'd72);
                2: t = one - (((x2 * t) >> 30) / 64'd42);
                3: t = one - (((x2 * t) >> 30) / 64'd20);
                default: t = one - (((x2 * t) >> 30) / 64'd6);
            endcase
        end
        s = (x * t) >> 30;
        s = (s + (64'd1 << 15)) >> 16;
        if (s > 64'(SIN_ONE)) s = 64'(SIN_ONE);
        return s[14:0];
    endfunction

endpackage

`default_nettype wire

[design/omni_mix_ctrl.sv]
// Sequencing state machine for the omni chassis mixer.
// Depends on omni_mix_pkg; drives the datapath through t_dp_cmd.
`default_nettype none

module omni_mix_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_op,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  omni_mix_pkg::t_dp_stat i_stat,
    output omni_mix_pkg::t_dp_cmd  o_cmd
);
    import omni_mix_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SIN_A  = 10'b00_0000_0010,
        S_SIN_B  = 10'b00_0000_0100,
        S_FF     = 10'b00_0000_1000,
        S_HEAD_P = 10'b00_0001_0000,
        S_HEAD_D = 10'b00_0010_0000,
        S_MIX    = 10'b00_0100_0000,
        S_WMUL   = 10'b00_1000_0000,
        S_DIV    = 10'b01_0000_0000,
        S_OUT    = 10'b10_0000_0000
    } t_state;

    localparam int CW = $clog2(QUOT_BITS);

    t_state          r_state, n_state;
    logic            r_roll, n_roll;
    logic [1:0]      r_wheel, n_wheel;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_out_valid;

    logic w_take;
    logic w_out_free;
    logic w_div_last;

    assign w_take     = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_div_last = (r_state == S_DIV) && (r_cnt == CW'(QUOT_BITS - 1));

    always_comb begin
        n_state = r_state;
        n_roll  = r_roll;
        n_wheel = r_wheel;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_take && (t_op'(i_op) == OP_UPDATE)) begin
                    n_roll  = 1'b0;
                    n_wheel = '0;
                    n_state = i_stat.quick ? S_OUT : S_SIN_A;
                end
            end
            S_SIN_A:  n_state = S_SIN_B;
            S_SIN_B:  n_state = S_FF;
            S_FF: begin
                if (!r_roll) begin
                    n_roll  = 1'b1;
                    n_state = S_SIN_A;
                end else begin
                    n_state = S_HEAD_P;
                end
            end
            S_HEAD_P: n_state = S_HEAD_D;
            S_HEAD_D: n_state = S_MIX;
            S_MIX:    n_state = S_WMUL;
            S_WMUL: begin
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_last) begin
                    if (r_wheel == 2'(NUM_WHEELS - 1)) begin
                        n_state = S_OUT;
                    end else begin
                        n_wheel = r_wheel + 2'd1;
                        n_state = S_WMUL;
                    end
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_OUT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_roll      <= 1'b0;
            r_wheel     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_roll  <= n_roll;
            r_wheel <= n_wheel;
            r_cnt   <= n_cnt;
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.take      = w_take;
        o_cmd.err_load  = (r_state == S_SIN_A) && !r_roll;
        o_cmd.sin_a     = (r_state == S_SIN_A);
        o_cmd.sin_b     = (r_state == S_SIN_B);
        o_cmd.ff_load   = (r_state == S_FF);
        o_cmd.roll_sel  = r_roll;
        o_cmd.head_p    = (r_state == S_HEAD_P);
        o_cmd.head_d    = (r_state == S_HEAD_D);
        o_cmd.mix       = (r_state == S_MIX);
        o_cmd.wheel_mul = (r_state == S_WMUL);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.div_last  = w_div_last;
        o_cmd.wheel     = r_wheel;
        o_cmd.out_load  = (r_state == S_OUT) && w_out_free;
    end

    a_rise_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result beat raised outside the output state");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CW'(QUOT_BITS)))
        else $error("divider step count out of range");

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && !w_div_last) |=> ((r_state == S_DIV) && $stable(r_wheel)))
        else $error("divider left early or wheel changed mid divide");

endmodule

`default_nettype wire

[design/omni_mix_dp.sv]
// Datapath of the omni chassis mixer: held command, gains, sine lookup,
// heading hold, wheel mixing and the shared restoring divider. Depends on omni_mix_pkg.
`default_nettype none

module omni_mix_dp #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  omni_mix_pkg::t_dp_cmd  i_cmd,
    output omni_mix_pkg::t_dp_stat o_stat,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [14:0]            i_cfg_data,
    input  logic [1:0]             i_op,
    input  logic signed [15:0]     i_vel_x,
    input  logic signed [15:0]     i_vel_y,
    input  logic signed [15:0]     i_spin,
    input  logic signed [15:0]     i_yaw,
    input  logic [14:0]            i_speed_limit,
    input  logic signed [15:0]     i_gyro_rate,
    input  logic signed [13:0]     i_roll_angle,
    input  logic signed [13:0]     i_pitch_angle,
    output logic [1:0]             o_status,
    output logic signed [15:0]     o_wheel_front_left,
    output logic signed [15:0]     o_wheel_front_right,
    output logic signed [15:0]     o_wheel_rear_right,
    output logic signed [15:0]     o_wheel_rear_left
);
    import omni_mix_pkg::*;

    localparam int IW = $clog2(SINE_TABLE_DEPTH);
    localparam int XW = $clog2(QUARTER_TURN * SINE_TABLE_DEPTH + QUARTER_TURN / 2 + 1);
    localparam int YW = XW - SIX_BITS;
    localparam int PW = YW + RECIP_BITS;
    localparam int RW = 19;

    function automatic logic signed [17:0] wrap_angle(input logic signed [17:0] a);
        logic signed [17:0] v;
        v = a;
        for (int k = 0; k < 3; k++) begin
            if (v > 18'sd11520) v = v - 18'sd23040;
            else if (v < -18'sd11520) v = v + 18'sd23040;
        end
        return v;
    endfunction

    function automatic logic signed [39:0] rnd_shr(input logic signed [39:0] v,
                                                   input int unsigned k);
        logic signed [39:0] half;
        logic signed [39:0] r;
        half = 40'sd1 <<< (k - 1);
        if (v >= 0) r = (v + half) >>> k;
        else r = -((-v + half) >>> k);
        return r;
    endfunction

    function automatic logic big(input logic signed [15:0] v);
        return (v > 16'sd123) || (v < -16'sd123);
    endfunction

    logic [14:0] w_rom [SINE_TABLE_DEPTH];
    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
        localparam logic [63:0] X_POS = (64'(gi) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
        assign w_rom[gi] = sine_entry(X_POS);
    end

    logic [13:0]        r_kp;
    logic [11:0]        r_kd;
    logic signed [14:0] r_ffp, r_ffr;
    logic signed [15:0] r_vx, r_vy, r_spin, r_ref;
    logic [14:0]        r_lim;
    logic               r_active;

    logic signed [15:0] r_yaw, r_gyro;
    logic signed [13:0] r_roll, r_pitch;

    logic [IW:0]        r_sq0;
    logic [YW-1:0]      r_sy;
    logic               r_sneg;
    logic signed [15:0] r_sin;
    logic signed [16:0] r_fx, r_fy;
    logic signed [14:0] r_e;
    logic signed [30:0] r_hacc;
    logic signed [16:0] r_w;
    logic signed [18:0] r_wv [NUM_WHEELS];
    logic [17:0]        r_den;
    logic [RW-1:0]      r_rem;
    logic [QUOT_BITS-1:0] r_dnum, r_q;
    logic               r_dneg;
    logic signed [15:0] r_wheel [NUM_WHEELS];
    logic [1:0]         r_o_status;
    logic signed [15:0] r_o_wheel [NUM_WHEELS];

    logic signed [14:0] w_cfg_s;
    assign w_cfg_s = $signed(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp  <= 14'(GAIN_P_RESET);
            r_kd  <= 12'(GAIN_D_RESET);
            r_ffp <= '0;
            r_ffr <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAIN_P: begin
                    if (i_cfg_data[13:0] <= 14'(GAIN_P_MAX)) r_kp <= i_cfg_data[13:0];
                end
                CFG_GAIN_D: begin
                    if (i_cfg_data[11:0] <= 12'(GAIN_D_MAX)) r_kd <= i_cfg_data[11:0];
                end
                CFG_FF_PITCH: begin
                    if (w_cfg_s >= -15'sd8192 && w_cfg_s <= 15'sd8192) r_ffp <= w_cfg_s;
                end
                CFG_FF_ROLL: begin
                    if (w_cfg_s >= -15'sd8192 && w_cfg_s <= 15'sd8192) r_ffr <= w_cfg_s;
                end
                default: ;
            endcase
        end
    end

    logic w_moving;
    assign w_moving = big(i_vel_x) || big(i_vel_y) || big(i_spin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx     <= '0;
            r_vy     <= '0;
            r_spin   <= '0;
            r_ref    <= '0;
            r_lim    <= '0;
            r_active <= 1'b0;
        end else if (i_cmd.take) begin
            unique case (t_op'(i_op))
                OP_COMMAND: begin
                    if (!w_moving) begin
                        r_active <= 1'b0;
                    end else begin
                        if (!r_active || big(i_spin)) r_ref <= i_yaw;
                        r_vx     <= i_vel_x;
                        r_vy     <= i_vel_y;
                        r_spin   <= i_spin;
                        r_lim    <= i_speed_limit;
                        r_active <= 1'b1;
                    end
                end
                OP_HEADING: begin
                    r_vx     <= '0;
                    r_vy     <= '0;
                    r_spin   <= '0;
                    r_ref    <= 16'(wrap_angle(18'(i_yaw)));
                    r_lim    <= i_speed_limit;
                    r_active <= 1'b1;
                end
                OP_STOP: begin
                    r_vx     <= '0;
                    r_vy     <= '0;
                    r_spin   <= '0;
                    r_ref    <= '0;
                    r_lim    <= '0;
                    r_active <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (t_op'(i_op) == OP_UPDATE)) begin
            r_yaw   <= i_yaw;
            r_gyro  <= i_gyro_rate;
            r_roll  <= i_roll_angle;
            r_pitch <= i_pitch_angle;
        end
    end

    assign o_stat.quick = !r_active || (r_lim == '0);

    // Sine lookup: fold, scale to a table index, divide by 5760 via shift and reciprocal.
    logic signed [13:0] w_ang;
    logic [13:0]        w_mag, w_fold;
    logic [XW-1:0]      w_x;
    logic [YW-1:0]      w_y;
    logic [PW-1:0]      w_sprod;
    logic [YW-1:0]      w_srem;
    logic [IW:0]        w_idx;
    logic [14:0]        w_smag;

    assign w_ang   = i_cmd.roll_sel ? r_roll : r_pitch;
    assign w_mag   = w_ang[13] ? 14'(-w_ang) : 14'(w_ang);
    assign w_fold  = (w_mag > 14'(QUARTER_TURN)) ? 14'(HALF_TURN) - w_mag : w_mag;
    assign w_x     = XW'(w_fold) * XW'(SINE_TABLE_DEPTH) + XW'(QUARTER_TURN / 2);
    assign w_y     = w_x[XW-1:SIX_BITS];
    assign w_sprod = PW'(w_y) * PW'(RECIP_90);
    assign w_srem  = r_sy - YW'(r_sq0) * YW'(DIV_NINETY);
    assign w_idx   = (w_srem >= YW'(DIV_NINETY)) ? r_sq0 + (IW+1)'(1) : r_sq0;
    assign w_smag  = (w_idx >= (IW+1)'(SINE_TABLE_DEPTH)) ? 15'(SIN_ONE)
                                                          : w_rom[w_idx[IW-1:0]];

    logic signed [14:0] w_ffg;
    logic signed [30:0] w_ffprod;
    logic signed [39:0] w_ffr;
    assign w_ffg    = i_cmd.roll_sel ? r_ffr : r_ffp;
    assign w_ffprod = 31'(w_ffg) * 31'(r_sin);
    assign w_ffr    = rnd_shr(40'(w_ffprod), 16);

    logic signed [17:0] w_diff;
    assign w_diff = 18'(r_ref) - 18'(r_yaw);

    logic signed [30:0] w_hp;
    logic signed [30:0] w_dterm;
    logic signed [32:0] w_tot;
    logic signed [39:0] w_hr;
    assign w_hp    = 31'($signed({1'b0, r_kp})) * 31'(r_e);
    assign w_dterm = 31'($signed({1'b0, r_kd})) * 31'(r_gyro);
    assign w_tot   = 33'(r_hacc) - (33'(w_dterm) <<< 2);
    assign w_hr    = rnd_shr(40'(w_tot), 10);

    logic signed [16:0] w_rot;
    logic signed [18:0] w_wv [NUM_WHEELS];
    logic [17:0]        w_abs [NUM_WHEELS];
    logic [17:0]        w_peak;
    assign w_rot = big(r_spin) ? 17'(r_spin) : r_w;
    assign w_wv[0] = 19'(r_fx) - 19'(r_fy) - 19'(w_rot);
    assign w_wv[1] = 19'(r_fx) + 19'(r_fy) - 19'(w_rot);
    assign w_wv[2] = 19'(r_fx) + 19'(r_fy) + 19'(w_rot);
    assign w_wv[3] = 19'(r_fx) - 19'(r_fy) + 19'(w_rot);
    always_comb begin
        w_peak = '0;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            w_abs[i] = w_wv[i][18] ? 18'(-w_wv[i]) : 18'(w_wv[i]);
            if (w_abs[i] > w_peak) w_peak = w_abs[i];
        end
    end

    logic signed [34:0] w_wprod;
    logic [33:0]        w_wmag;
    logic [34:0]        w_num;
    assign w_wprod = 35'(r_wv[i_cmd.wheel]) * 35'($signed({1'b0, r_lim}));
    assign w_wmag  = w_wprod[34] ? 34'(-w_wprod) : 34'(w_wprod);
    assign w_num   = 35'(w_wmag) + 35'(r_den >> 1);

    logic [RW-1:0]        w_trial;
    logic                 w_ge;
    logic [QUOT_BITS-1:0] w_q;
    assign w_trial = {r_rem[RW-2:0], r_dnum[QUOT_BITS-1]};
    assign w_ge    = (w_trial >= RW'(r_den));
    assign w_q     = {r_q[QUOT_BITS-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sin_a) begin
            r_sq0  <= w_sprod[RECIP_SHIFT +: IW+1];
            r_sy   <= w_y;
            r_sneg <= w_ang[13];
        end
        if (i_cmd.err_load) begin
            r_e <= 15'(wrap_angle(w_diff));
        end
        if (i_cmd.sin_b) begin
            r_sin <= r_sneg ? -$signed({1'b0, w_smag}) : $signed({1'b0, w_smag});
        end
        if (i_cmd.ff_load) begin
            if (i_cmd.roll_sel) r_fy <= 17'(r_vy) - 17'(w_ffr);
            else r_fx <= 17'(r_vx) + 17'(w_ffr);
        end
        if (i_cmd.head_p) begin
            r_hacc <= w_hp;
        end
        if (i_cmd.head_d) begin
            if (w_hr > 40'sd1434) r_w <= 17'sd1434;
            else if (w_hr < -40'sd1434) r_w <= -17'sd1434;
            else r_w <= 17'(w_hr);
        end
        if (i_cmd.mix) begin
            for (int i = 0; i < NUM_WHEELS; i++) r_wv[i] <= w_wv[i];
            r_den <= (w_peak > 18'(UNIT_Q12)) ? w_peak : 18'(UNIT_Q12);
        end
        if (i_cmd.wheel_mul) begin
            r_rem  <= RW'(w_num >> QUOT_BITS);
            r_dnum <= w_num[QUOT_BITS-1:0];
            r_dneg <= r_wv[i_cmd.wheel][18];
            r_q    <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_trial - RW'(r_den) : w_trial;
            r_dnum <= r_dnum << 1;
            r_q    <= w_q;
            if (i_cmd.div_last) begin
                r_wheel[i_cmd.wheel] <= r_dneg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
            end
        end
        if (i_cmd.out_load) begin
            if (!r_active) r_o_status <= STAT_INACTIVE;
            else if (r_lim == '0) r_o_status <= STAT_NO_LIMIT;
            else r_o_status <= STAT_DRIVE;
            for (int i = 0; i < NUM_WHEELS; i++) begin
                r_o_wheel[i] <= (r_active && (r_lim != '0)) ? r_wheel[i] : '0;
            end
        end
    end

    assign o_status            = r_o_status;
    assign o_wheel_front_left  = r_o_wheel[0];
    assign o_wheel_front_right = r_o_wheel[1];
    assign o_wheel_rear_right  = r_o_wheel[2];
    assign o_wheel_rear_left   = r_o_wheel[3];

endmodule

`default_nettype wire

[design/omni_chassis_heading_hold_mixer.sv]
// Top level of the omni chassis mixer with heading hold.
// Depends on omni_mix_pkg, omni_mix_ctrl and omni_mix_dp.
//
// Commands, heading targets and stops are applied when taken and leave the
// controller idle. An update beat on an inactive block or one with a zero speed
// limit goes straight to the output state. A driven update runs two sine lookups,
// each in S_SIN_A, S_SIN_B and S_FF, then heading hold and mixing in S_HEAD_P,
// S_HEAD_D and S_MIX, then for each wheel S_WMUL and one shared restoring divider
// that produces the 15-bit scaled speed, one cycle per quotient bit. The result
// waits in an output register, so the next beat may be taken while it is still held.
`default_nettype none

module omni_chassis_heading_hold_mixer #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic signed [15:0] i_vel_x,
    input  logic signed [15:0] i_vel_y,
    input  logic signed [15:0] i_spin,
    input  logic signed [15:0] i_yaw,
    input  logic [14:0]        i_speed_limit,
    input  logic signed [15:0] i_gyro_rate,
    input  logic signed [13:0] i_roll_angle,
    input  logic signed [13:0] i_pitch_angle,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [15:0] o_wheel_front_left,
    output logic signed [15:0] o_wheel_front_right,
    output logic signed [15:0] o_wheel_rear_right,
    output logic signed [15:0] o_wheel_rear_left
);
    import omni_mix_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    omni_mix_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    omni_mix_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_op                (i_op),
        .i_vel_x             (i_vel_x),
        .i_vel_y             (i_vel_y),
        .i_spin              (i_spin),
        .i_yaw               (i_yaw),
        .i_speed_limit       (i_speed_limit),
        .i_gyro_rate         (i_gyro_rate),
        .i_roll_angle        (i_roll_angle),
        .i_pitch_angle       (i_pitch_angle),
        .o_status            (o_status),
        .o_wheel_front_left  (o_wheel_front_left),
        .o_wheel_front_right (o_wheel_front_right),
        .o_wheel_rear_right  (o_wheel_rear_right),
        .o_wheel_rear_left   (o_wheel_rear_left)
    );

endmodule

`default_nettype wire
